>>> src/wpm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wpm_pkg
// Shared types and constants for the wildcard pattern matcher.
// ---------------------------------------------------------------------------
package wpm_pkg;

  localparam int unsigned MaxPattern = 32;
  localparam int unsigned LenW       = $clog2(MaxPattern + 1);

  localparam logic [7:0] StarByte = 8'h2A;
  localparam logic [7:0] AnyByte  = 8'h3F;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_TEXT   = 2'd1,
    OP_END    = 2'd2,
    OP_CLEAR  = 2'd3
  } wpm_op_e;

  // per-cell control
  typedef struct packed {
    logic update;   // load the new row bit
    logic text;     // advance by a text byte (else rearm for empty text)
    logic wr;       // capture the incoming pattern byte
    logic active;   // cell lies inside the (new) pattern length
  } wpm_cell_ctrl_t;

endpackage

>>> src/wpm_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wpm_in_if / wpm_out_if
// Valid/ready channels for command items and match results.
// ---------------------------------------------------------------------------
interface wpm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] symbol;

  modport source (output valid, output opcode, output symbol, input ready);
  modport sink   (input valid, input opcode, input symbol, output ready);
endinterface

interface wpm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic overflowed;

  modport source (output valid, output matched, output overflowed, input ready);
  modport sink   (input valid, input matched, input overflowed, output ready);
endinterface

>>> src/wildcard_pattern_match.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wildcard_pattern_match
// Whole-text matcher for patterns with '*' and '?', built as a cell chain.
// ---------------------------------------------------------------------------
//  channel  dir  payload               item
//  in_i     in   opcode[1:0] symbol[7:0] append / text / end / clear
//  out_o    out  matched overflowed    one per end item
//
// The new row for each item ripples through all MaxPattern cells in the
// cycle the item is taken, so the cell chain sets the clock period.
// An end item's result sits in an output register; the next item is taken
// while it waits unless the register is full and out_o.ready is low.
// After reset the pattern is empty and the row holds only bit zero.
// ---------------------------------------------------------------------------
module wildcard_pattern_match
  import wpm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  wpm_in_if.sink    in_i,
  wpm_out_if.source out_o
);

  logic            acc;
  wpm_op_e         op;
  logic [LenW-1:0] len_q, len_d;
  logic            ovf_q, ovf_d;
  logic            row0_q;
  logic            full;
  logic            out_valid_q, matched_q, overflowed_q;
  logic [MaxPattern:0] row;
  logic [MaxPattern:0] chain;

  assign op    = wpm_op_e'(in_i.opcode);
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign acc   = in_i.valid && in_i.ready;
  assign full  = (len_q == LenW'(MaxPattern));

  always_comb begin
    len_d = len_q;
    ovf_d = ovf_q;
    if (acc) begin
      unique case (op)
        OP_APPEND: begin
          if (full) ovf_d = 1'b1;
          else      len_d = len_q + LenW'(1);
        end
        OP_CLEAR: begin
          len_d = '0;
          ovf_d = 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign row[0]   = row0_q;
  assign chain[0] = (op != OP_TEXT);

  for (genvar j = 0; j < MaxPattern; j++) begin : g_cell
    wpm_cell_ctrl_t ctrl;
    assign ctrl.update = acc;
    assign ctrl.text   = (op == OP_TEXT);
    assign ctrl.wr     = acc && (op == OP_APPEND) && !full && (len_q == LenW'(j));
    assign ctrl.active = (LenW'(j) < len_d);

    wpm_cell u_cell (
      .clk_i,
      .rst_ni,
      .ctrl_i     (ctrl),
      .sym_i      (in_i.symbol),
      .prev_row_i (row[j]),
      .chain_i    (chain[j]),
      .row_o      (row[j+1]),
      .chain_o    (chain[j+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      ovf_q       <= 1'b0;
      row0_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      len_q <= len_d;
      ovf_q <= ovf_d;
      if (acc) begin
        row0_q <= (op != OP_TEXT);
      end
      if (acc && op == OP_END) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && op == OP_END) begin
      matched_q    <= !ovf_q && row[len_q];
      overflowed_q <= ovf_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.matched    = matched_q;
  assign out_o.overflowed = overflowed_q;

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> full) else $error("overflow with store not full");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenW'(MaxPattern)) else $error("pattern length out of range");

  a_end_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && op == OP_END) |=> out_valid_q) else $error("end item gave no result");

  a_text_row0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && op == OP_TEXT) |=> !row0_q) else $error("row bit zero set after text");

  a_rearm_row0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && op != OP_TEXT) |=> row0_q) else $error("row not rearmed");

endmodule

>>> src/wpm_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wpm_cell
// One pattern position: holds its pattern byte and its prefix-match bit.
// ---------------------------------------------------------------------------
module wpm_cell
  import wpm_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  wpm_cell_ctrl_t ctrl_i,
  input  logic [7:0]     sym_i,
  input  logic           prev_row_i,  // current row bit of the left neighbor
  input  logic           chain_i,     // new row bit of the left neighbor
  output logic           row_o,
  output logic           chain_o
);

  logic [7:0] pat_q;
  logic       row_q, row_d;
  logic [7:0] eff;
  logic       is_star, is_any, cand;

  assign eff     = ctrl_i.wr ? sym_i : pat_q;
  assign is_star = (eff == StarByte);
  assign is_any  = (eff == AnyByte);

  always_comb begin
    if (ctrl_i.text) begin
      cand = is_star ? (row_q | chain_i) : (prev_row_i & (is_any | (eff == sym_i)));
    end else begin
      cand = is_star & chain_i;
    end
    row_d = ctrl_i.active & cand;
  end

  assign chain_o = row_d;
  assign row_o   = row_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr) begin
      pat_q <= sym_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= 1'b0;
    end else if (ctrl_i.update) begin
      row_q <= row_d;
    end
  end

endmodule
